// File: hdl/dma_linked_list_walker_core_defines.svh
// assertion macros for the checker file of the list walker
// no dependencies; included by name where assertions are written
`ifndef DMA_LINKED_LIST_WALKER_CORE_DEFINES_SVH
`define DMA_LINKED_LIST_WALKER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DLLW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dllw assertion failed");

// next-cycle implication, disabled while reset is held
`define DLLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dllw assertion failed");

`endif

// File: hdl/dllw_pkg.sv
// types, codes and constants of the linked-list dma walker
// no dependencies; imported by every module of the block
package dllw_pkg;

  localparam int unsigned HEADER_CLOCKS = 8;
  localparam int unsigned SETUP_CLOCKS  = 5;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PTR_W   = 24;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CD_W    = 9;
  localparam int unsigned PADDR_W = 3;

  localparam logic [PTR_W-1:0]  END_MARK      = 24'hFF_FFFF;
  localparam logic [PTR_W-1:0]  LIMIT_RESET   = 24'hFF_FFFF;
  localparam logic [ADDR_W-1:0] WORD_BYTES    = 32'd4;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_REPLY   = 2'd2,
    REQ_CANCEL  = 2'd3
  } req_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_READ = 2'd1,
    KIND_WORD = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  // walk phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_HDR_WAIT = 3'd2,
    PH_SETUP    = 3'd3,
    PH_PAY_WAIT = 3'd4,
    PH_COMPLETE = 3'd5
  } phase_e;

  // register indexes of the configuration port
  localparam logic REG_NODE_LIMIT = 1'b0;

  // walker state
  typedef struct packed {
    logic              active;
    phase_e            phase;
    logic [ADDR_W-1:0] node_address;
    logic [PTR_W-1:0]  next_pointer;
    logic [CNT_W-1:0]  payload_count;
    logic [CNT_W-1:0]  payload_index;
    logic [ADDR_W-1:0] payload_address;
    logic [CD_W-1:0]   countdown;
    logic [PTR_W-1:0]  nodes_done;
  } walk_state_t;

  // one result item
  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] word;
    logic              limit_hit;
    logic [CD_W-1:0]   cycles_to_event;
    logic              last;
  } result_t;

endpackage

// File: hdl/dma_linked_list_walker_core.sv
// top level of the linked-list dma walker: state, config register, output buffer
// depends on dllw_pkg, dllw_step, dllw_result_queue
//
// Requests come in on a valid/ready channel (req_type with start address,
// elapsed clocks or read data); results leave on a valid/ready channel of
// their own. A request is accepted on a clock where in_valid_i and in_ready_o
// are both high, and its first result is offered on the following clock.
// Each request yields one result, or two when a payload word is emitted and
// the next payload read is requested; last_o marks the final one.
// One request per clock is sustained while every request gives one result
// and the receiver keeps up; a two-result request holds off the next request
// until its second result leaves the two-entry result buffer, which has a single output port.
// When the receiver stalls, results wait in that buffer and in_ready_o drops
// as soon as the buffer cannot take a full two results.
// node_limit is written through the APB port where paddr[2] is low and read back
// at any address; pready is tied high. Writes belong in idle periods only.
// Reset clears the walk to idle, empties the result buffer and sets
// node_limit to all ones.
module dma_linked_list_walker_core import dllw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [ADDR_W-1:0]  start_address_i,
  input  logic [DATA_W-1:0]  elapsed_cycles_i,
  input  logic [DATA_W-1:0]  read_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [ADDR_W-1:0]  address_o,
  output logic [DATA_W-1:0]  word_out_o,
  output logic               limit_hit_o,
  output logic [CD_W-1:0]    cycles_to_event_o,
  output logic               last_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  walk_state_t      st_q, st_d, st_next;
  logic [PTR_W-1:0] node_limit_q;
  result_t          res0, res1, head;
  logic             two;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  // per-request logic
  dllw_step u_step (
    .st_i            (st_q),
    .node_limit_i    (node_limit_q),
    .req_type_i      (req_type_i),
    .start_address_i (start_address_i),
    .elapsed_cycles_i(elapsed_cycles_i),
    .read_data_i     (read_data_i),
    .st_o            (st_next),
    .res0_o          (res0),
    .res1_o          (res1),
    .two_o           (two)
  );

  assign st_d = accept ? st_next : st_q;

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // node limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_LIMIT)) begin
      node_limit_q <= pwdata[PTR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {{(32-PTR_W){1'b0}}, node_limit_q};

  // result buffer
  dllw_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res0_i     (res0),
    .res1_i     (res1),
    .two_i      (two),
    .pop_ready_i(out_ready_i),
    .room_o     (in_ready_o),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign kind_o            = head.kind;
  assign address_o         = head.address;
  assign word_out_o        = head.word;
  assign limit_hit_o       = head.limit_hit;
  assign cycles_to_event_o = head.cycles_to_event;
  assign last_o            = head.last;

endmodule

// File: hdl/dllw_step.sv
// next-state and result logic for one request of the list walker
// depends on dllw_pkg
module dllw_step import dllw_pkg::*; (
  input  walk_state_t       st_i,
  input  logic [PTR_W-1:0]  node_limit_i,
  input  logic [1:0]        req_type_i,
  input  logic [ADDR_W-1:0] start_address_i,
  input  logic [DATA_W-1:0] elapsed_cycles_i,
  input  logic [DATA_W-1:0] read_data_i,
  output walk_state_t       st_o,
  output result_t           res0_o,
  output result_t           res1_o,
  output logic              two_o
);

  logic [CNT_W-1:0]  idx_inc;
  logic [ADDR_W-1:0] next_node;
  logic [CD_W-1:0]   cte;

  assign idx_inc   = st_i.payload_index + CNT_W'(1);
  assign next_node = {{(ADDR_W-PTR_W){1'b0}}, read_data_i[PTR_W-1:0]};

  // state transition and results
  always_comb begin
    st_o   = st_i;
    res0_o = '0;
    res1_o = '0;
    two_o  = 1'b0;
    case (req_e'(req_type_i))
      REQ_START: begin
        st_o              = '0;
        st_o.active       = 1'b1;
        st_o.phase        = PH_HEADER;
        st_o.node_address = start_address_i;
        st_o.countdown    = CD_W'(HEADER_CLOCKS);
      end
      REQ_ADVANCE: begin
        if (st_i.active && (elapsed_cycles_i != '0) &&
            (st_i.phase != PH_HDR_WAIT) && (st_i.phase != PH_PAY_WAIT)) begin
          if (elapsed_cycles_i < {{(DATA_W-CD_W){1'b0}}, st_i.countdown}) begin
            st_o.countdown = st_i.countdown - elapsed_cycles_i[CD_W-1:0];
          end else begin
            // boundary reached
            st_o.countdown = '0;
            case (st_i.phase)
              PH_HEADER: begin
                if (st_i.nodes_done >= node_limit_i) begin
                  st_o.active      = 1'b0;
                  st_o.phase       = PH_IDLE;
                  res0_o.kind      = KIND_DONE;
                  res0_o.limit_hit = 1'b1;
                end else begin
                  st_o.phase     = PH_HDR_WAIT;
                  res0_o.kind    = KIND_READ;
                  res0_o.address = st_i.node_address;
                end
              end
              PH_SETUP: begin
                st_o.payload_index   = '0;
                st_o.payload_address = st_i.node_address + WORD_BYTES;
                st_o.phase           = PH_PAY_WAIT;
                res0_o.kind          = KIND_READ;
                res0_o.address       = st_i.node_address + WORD_BYTES;
              end
              PH_COMPLETE: begin
                st_o.active = 1'b0;
                st_o.phase  = PH_IDLE;
                res0_o.kind = KIND_DONE;
              end
              default: begin
                st_o.active      = 1'b0;
                st_o.phase       = PH_IDLE;
                res0_o.kind      = KIND_DONE;
                res0_o.limit_hit = 1'b1;
              end
            endcase
          end
        end
      end
      REQ_REPLY: begin
        if (st_i.active && (st_i.phase == PH_HDR_WAIT)) begin
          // header word: count and next pointer
          st_o.payload_count = read_data_i[DATA_W-1:PTR_W];
          st_o.next_pointer  = read_data_i[PTR_W-1:0];
          st_o.nodes_done    = st_i.nodes_done + PTR_W'(1);
          if (read_data_i[DATA_W-1:PTR_W] != '0) begin
            st_o.phase     = PH_SETUP;
            st_o.countdown = CD_W'(SETUP_CLOCKS);
          end else if (read_data_i[PTR_W-1:0] == END_MARK) begin
            st_o.active    = 1'b0;
            st_o.phase     = PH_IDLE;
            st_o.countdown = '0;
            res0_o.kind    = KIND_DONE;
          end else begin
            st_o.node_address = next_node;
            st_o.phase        = PH_HEADER;
            st_o.countdown    = CD_W'(HEADER_CLOCKS);
          end
        end else if (st_i.active && (st_i.phase == PH_PAY_WAIT)) begin
          // payload word out, then next word, next node or end of the list
          res0_o.kind        = KIND_WORD;
          res0_o.address     = st_i.payload_address;
          res0_o.word        = read_data_i;
          st_o.payload_index = idx_inc;
          if (idx_inc < st_i.payload_count) begin
            st_o.payload_address = st_i.payload_address + WORD_BYTES;
            res1_o.kind          = KIND_READ;
            res1_o.address       = st_i.payload_address + WORD_BYTES;
            two_o                = 1'b1;
          end else if (st_i.next_pointer == END_MARK) begin
            st_o.phase     = PH_COMPLETE;
            st_o.countdown = {1'b0, st_i.payload_count};
          end else begin
            st_o.phase        = PH_HEADER;
            st_o.node_address = {{(ADDR_W-PTR_W){1'b0}}, st_i.next_pointer};
            st_o.countdown    = {1'b0, st_i.payload_count} + CD_W'(HEADER_CLOCKS);
          end
        end
      end
      default: begin
        st_o = '0;
      end
    endcase

    // clocks to the next boundary, same on every result
    cte = '0;
    if (st_o.active) begin
      cte = (st_o.countdown != '0) ? st_o.countdown : CD_W'(1);
    end
    res0_o.cycles_to_event = cte;
    res1_o.cycles_to_event = cte;
    res0_o.last            = !two_o;
    res1_o.last            = 1'b1;
  end

endmodule

// File: hdl/dllw_result_queue.sv
// two-entry result buffer between the step logic and the output channel
// depends on dllw_pkg
module dllw_result_queue import dllw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res0_i,
  input  result_t res1_i,
  input  logic    two_i,
  input  logic    pop_ready_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t    ent0_q, ent0_d;
  result_t    ent1_q, ent1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && pop_ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent0_q;
  // both slots free once this cycle's pop has gone
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_ready_i);

  // pop shifts the second slot forward; a push lands in an empty buffer
  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    cnt_d  = cnt_q;
    if (pop) begin
      ent0_d = ent1_q;
      cnt_d  = cnt_q - 2'd1;
    end
    if (push_i) begin
      ent0_d = res0_i;
      ent1_d = res1_i;
      cnt_d  = two_i ? 2'd2 : 2'd1;
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result slots
  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule

// File: hdl/dllw_checker.sv
// port-level checks of the list walker, bound to the top level
// depends on dllw_pkg and dma_linked_list_walker_core_defines.svh
`include "dma_linked_list_walker_core_defines.svh"

module dllw_checker import dllw_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [1:0]      kind_o,
  input logic [DATA_W-1:0] word_out_o,
  input logic            limit_hit_o,
  input logic [CD_W-1:0] cycles_to_event_o
);

  // a stalled result stays offered
  `DLLW_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // a finished walk reports no pending boundary
  `DLLW_ASSERT_NOW(a_done_idle, clk_i, rst_ni, out_valid_o && (kind_o == KIND_DONE), cycles_to_event_o == '0)

  // data only travels with payload words
  `DLLW_ASSERT_NOW(a_word_only_payload, clk_i, rst_ni, out_valid_o && (kind_o != KIND_WORD), word_out_o == '0)

  // limit flag only travels with completion
  `DLLW_ASSERT_NOW(a_limit_only_done, clk_i, rst_ni, out_valid_o && (kind_o != KIND_DONE), !limit_hit_o)

endmodule

bind dma_linked_list_walker_core dllw_checker u_dllw_checker (.*);
